FILE: design/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// snfcs_pkg: shared types and constants of the flash command sequencer
// Holds the transaction payload structs, the command opcodes and the flash
// command codes used by the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
package snfcs_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  opcode_sel;
    logic [23:0] address;
    logic [12:0] count;
    logic [7:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  spi_byte;
    logic        spi_valid;
    logic        frame_end;
    logic        want_rx;
    logic [15:0] read_data;
    logic        read_valid;
    logic        done_res;
    logic        ok;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    FUNC_CMD  = 2'd0,
    FUNC_DATA = 2'd1,
    FUNC_RX   = 2'd2,
    FUNC_TICK = 2'd3
  } func_e;

  localparam logic [3:0] OP_RDSR  = 4'd0;
  localparam logic [3:0] OP_WRSR  = 4'd1;
  localparam logic [3:0] OP_WREN  = 4'd2;
  localparam logic [3:0] OP_WRDI  = 4'd3;
  localparam logic [3:0] OP_PD    = 4'd4;
  localparam logic [3:0] OP_WAKE  = 4'd5;
  localparam logic [3:0] OP_ID    = 4'd6;
  localparam logic [3:0] OP_PROG  = 4'd7;
  localparam logic [3:0] OP_SE    = 4'd8;
  localparam logic [3:0] OP_CE    = 4'd9;
  localparam logic [3:0] OP_READ  = 4'd10;

  localparam logic [7:0] C_RDSR  = 8'h05;
  localparam logic [7:0] C_WRSR  = 8'h01;
  localparam logic [7:0] C_WREN  = 8'h06;
  localparam logic [7:0] C_WRDI  = 8'h04;
  localparam logic [7:0] C_PP    = 8'h02;
  localparam logic [7:0] C_SE    = 8'h20;
  localparam logic [7:0] C_CE    = 8'hC7;
  localparam logic [7:0] C_PD    = 8'hB9;
  localparam logic [7:0] C_WAKE  = 8'hAB;
  localparam logic [7:0] C_READ  = 8'h03;
  localparam logic [7:0] C_DUMMY = 8'hFF;

  localparam int unsigned MaxRes = 6;

  // Result list produced by the front part for one accepted input item.
  typedef struct packed {
    logic [2:0]          n;
    out_item_t [MaxRes-1:0] res;
  } res_list_t;

  localparam logic [1:0] REG_PROG = 2'd0;
  localparam logic [1:0] REG_ERASE = 2'd1;
  localparam logic [1:0] REG_CHIP = 2'd2;

endpackage
`default_nettype wire

FILE: design/snfcs_front.sv
// ----------------------------------------------------------------------------
// snfcs_front: command front end
// Accepts input transactions, advances the operation state and builds the
// list of result transactions that each one causes.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_front #(
  parameter int unsigned SectorBytes = 4096,
  parameter int unsigned PageBytes   = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 take_i,
  input  wire snfcs_pkg::in_item_t  item_i,
  output snfcs_pkg::res_list_t      list_o
);
  import snfcs_pkg::*;

  localparam int unsigned SecShift = $clog2(SectorBytes);

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_RX_SR = 8'b0000_0010,
    PH_RX_IDH = 8'b0000_0100,
    PH_RX_IDL = 8'b0000_1000,
    PH_RX_RD = 8'b0001_0000,
    PH_PAY   = 8'b0010_0000,
    PH_PRE   = 8'b0100_0000,
    PH_POST  = 8'b1000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  op_q, op_d;
  logic [23:0] addr_q, addr_d;
  logic [12:0] left_q, left_d;
  logic [31:0] ticks_q, ticks_d;
  logic [7:0]  idh_q, idh_d;
  logic [31:0] prog_to_q, erase_to_q, chip_to_q;

  res_list_t   l;

  function automatic out_item_t mk_spi(logic [7:0] b, logic fe, logic rx);
    out_item_t o;
    o = '0;
    o.spi_byte = b; o.spi_valid = 1'b1; o.frame_end = fe; o.want_rx = rx;
    return o;
  endfunction

  function automatic out_item_t mk_done(logic okv);
    out_item_t o;
    o = '0;
    o.done_res = 1'b1; o.ok = okv;
    return o;
  endfunction

  function automatic out_item_t mk_read(logic [15:0] d, logic dn);
    out_item_t o;
    o = '0;
    o.read_data = d; o.read_valid = 1'b1; o.done_res = dn; o.ok = dn;
    return o;
  endfunction

  logic [12:0] pcnt, left_m1;
  logic [31:0] post_lim;
  logic [23:0] sec_addr;
  logic [SecShift+23:0] sec_wide;

  always_comb begin
    pcnt = item_i.count;
    if (pcnt == '0) pcnt = 13'd1;
    if (pcnt > 13'(PageBytes)) pcnt = 13'(PageBytes);
    left_m1 = left_q - 13'd1;
    sec_wide = {{SecShift{1'b0}}, item_i.address} << SecShift;
    sec_addr = sec_wide[23:0];
    if (op_q == OP_PROG) post_lim = prog_to_q;
    else if (op_q == OP_CE) post_lim = chip_to_q;
    else post_lim = erase_to_q;
  end

  always_comb begin
    phase_d = phase_q; op_d = op_q; addr_d = addr_q; left_d = left_q;
    ticks_d = ticks_q; idh_d = idh_q;
    l = '0;
    case (func_e'(item_i.func))
      FUNC_CMD: begin
        if (phase_q == PH_IDLE && item_i.opcode_sel <= OP_READ) begin
          op_d = item_i.opcode_sel;
          case (item_i.opcode_sel)
            OP_RDSR: begin
              l.res[0] = mk_spi(C_RDSR, 1'b0, 1'b0);
              l.res[1] = mk_spi(C_DUMMY, 1'b1, 1'b1);
              l.n = 3'd2; phase_d = PH_RX_SR;
            end
            OP_WRSR: begin
              l.res[0] = mk_spi(C_WRSR, 1'b0, 1'b0);
              l.res[1] = mk_spi(item_i.value, 1'b1, 1'b0);
              l.res[2] = mk_done(1'b1); l.n = 3'd3;
            end
            OP_WREN, OP_WRDI, OP_PD, OP_WAKE: begin
              case (item_i.opcode_sel)
                OP_WREN: l.res[0] = mk_spi(C_WREN, 1'b1, 1'b0);
                OP_WRDI: l.res[0] = mk_spi(C_WRDI, 1'b1, 1'b0);
                OP_PD:   l.res[0] = mk_spi(C_PD, 1'b1, 1'b0);
                default: l.res[0] = mk_spi(C_WAKE, 1'b1, 1'b0);
              endcase
              l.res[1] = mk_done(1'b1); l.n = 3'd2;
            end
            OP_ID: begin
              l.res[0] = mk_spi(item_i.value, 1'b0, 1'b0);
              l.res[1] = mk_spi(8'h00, 1'b0, 1'b0);
              l.res[2] = mk_spi(8'h00, 1'b0, 1'b0);
              l.res[3] = mk_spi(8'h00, 1'b0, 1'b0);
              l.res[4] = mk_spi(C_DUMMY, 1'b0, 1'b1);
              l.res[5] = mk_spi(C_DUMMY, 1'b1, 1'b1);
              l.n = 3'd6; phase_d = PH_RX_IDH;
            end
            OP_PROG: begin
              addr_d = item_i.address; left_d = pcnt;
              l.res[0] = mk_spi(C_WREN, 1'b1, 1'b0);
              l.res[1] = mk_spi(C_PP, 1'b0, 1'b0);
              l.res[2] = mk_spi(item_i.address[23:16], 1'b0, 1'b0);
              l.res[3] = mk_spi(item_i.address[15:8], 1'b0, 1'b0);
              l.res[4] = mk_spi(item_i.address[7:0], 1'b0, 1'b0);
              l.n = 3'd5; phase_d = PH_PAY;
            end
            OP_SE, OP_CE: begin
              if (item_i.opcode_sel == OP_SE) addr_d = sec_addr;
              l.res[0] = mk_spi(C_WREN, 1'b1, 1'b0);
              l.res[1] = mk_spi(C_RDSR, 1'b0, 1'b0);
              l.res[2] = mk_spi(C_DUMMY, 1'b1, 1'b1);
              l.n = 3'd3; ticks_d = '0; phase_d = PH_PRE;
            end
            default: begin
              addr_d = item_i.address; left_d = item_i.count;
              l.res[0] = mk_spi(C_READ, 1'b0, 1'b0);
              l.res[1] = mk_spi(item_i.address[23:16], 1'b0, 1'b0);
              l.res[2] = mk_spi(item_i.address[15:8], 1'b0, 1'b0);
              if (item_i.count == '0) begin
                l.res[3] = mk_spi(item_i.address[7:0], 1'b1, 1'b0);
                l.res[4] = mk_done(1'b1); l.n = 3'd5;
              end else begin
                l.res[3] = mk_spi(item_i.address[7:0], 1'b0, 1'b0);
                l.res[4] = mk_spi(C_DUMMY, item_i.count == 13'd1, 1'b1);
                l.n = 3'd5; phase_d = PH_RX_RD;
              end
            end
          endcase
        end
      end
      FUNC_DATA: begin
        if (phase_q == PH_PAY) begin
          left_d = left_m1;
          if (left_m1 == '0) begin
            l.res[0] = mk_spi(item_i.value, 1'b1, 1'b0);
            l.res[1] = mk_spi(C_RDSR, 1'b0, 1'b0);
            l.res[2] = mk_spi(C_DUMMY, 1'b1, 1'b1);
            l.n = 3'd3; ticks_d = '0; phase_d = PH_POST;
          end else begin
            l.res[0] = mk_spi(item_i.value, 1'b0, 1'b0); l.n = 3'd1;
          end
        end
      end
      FUNC_RX: begin
        case (phase_q)
          PH_RX_SR: begin
            l.res[0] = mk_read({8'h00, item_i.value}, 1'b1); l.n = 3'd1;
            phase_d = PH_IDLE;
          end
          PH_RX_IDH: begin
            idh_d = item_i.value; phase_d = PH_RX_IDL;
          end
          PH_RX_IDL: begin
            l.res[0] = mk_read({idh_q, item_i.value}, 1'b1); l.n = 3'd1;
            phase_d = PH_IDLE;
          end
          PH_RX_RD: begin
            left_d = left_m1;
            if (left_m1 == '0) begin
              l.res[0] = mk_read({8'h00, item_i.value}, 1'b1); l.n = 3'd1;
              phase_d = PH_IDLE;
            end else begin
              l.res[0] = mk_read({8'h00, item_i.value}, 1'b0);
              l.res[1] = mk_spi(C_DUMMY, left_m1 == 13'd1, 1'b1); l.n = 3'd2;
            end
          end
          PH_PRE: begin
            if (!item_i.value[0] || ticks_q > erase_to_q) begin
              if (op_q == OP_SE) begin
                l.res[0] = mk_spi(C_SE, 1'b0, 1'b0);
                l.res[1] = mk_spi(addr_q[23:16], 1'b0, 1'b0);
                l.res[2] = mk_spi(addr_q[15:8], 1'b0, 1'b0);
                l.res[3] = mk_spi(addr_q[7:0], 1'b1, 1'b0);
                l.res[4] = mk_spi(C_RDSR, 1'b0, 1'b0);
                l.res[5] = mk_spi(C_DUMMY, 1'b1, 1'b1); l.n = 3'd6;
              end else begin
                l.res[0] = mk_spi(C_CE, 1'b1, 1'b0);
                l.res[1] = mk_spi(C_RDSR, 1'b0, 1'b0);
                l.res[2] = mk_spi(C_DUMMY, 1'b1, 1'b1); l.n = 3'd3;
              end
              ticks_d = '0; phase_d = PH_POST;
            end else begin
              l.res[0] = mk_spi(C_RDSR, 1'b0, 1'b0);
              l.res[1] = mk_spi(C_DUMMY, 1'b1, 1'b1); l.n = 3'd2;
            end
          end
          PH_POST: begin
            if (!item_i.value[0]) begin
              l.res[0] = mk_done(1'b1); l.n = 3'd1; phase_d = PH_IDLE;
            end else if (ticks_q > post_lim) begin
              l.res[0] = mk_done(1'b0); l.n = 3'd1; phase_d = PH_IDLE;
            end else begin
              l.res[0] = mk_spi(C_RDSR, 1'b0, 1'b0);
              l.res[1] = mk_spi(C_DUMMY, 1'b1, 1'b1); l.n = 3'd2;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        if ((phase_q == PH_PRE || phase_q == PH_POST) && ticks_q != '1)
          ticks_d = ticks_q + 32'd1;
      end
    endcase
    if (l.n != '0) l.res[l.n - 3'd1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; op_q <= '0; addr_q <= '0; left_q <= '0;
      ticks_q <= '0; idh_q <= '0;
      prog_to_q <= 32'd5000; erase_to_q <= 32'd10000; chip_to_q <= 32'd40000;
    end else begin
      if (take_i) begin
        phase_q <= phase_d; op_q <= op_d; addr_q <= addr_d; left_q <= left_d;
        ticks_q <= ticks_d; idh_q <= idh_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROG:  prog_to_q <= cfg_data_i;
          REG_ERASE: erase_to_q <= cfg_data_i;
          REG_CHIP:  chip_to_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign list_o = l;

endmodule
`default_nettype wire

FILE: design/snfcs_back.sv
// ----------------------------------------------------------------------------
// snfcs_back: result queue and drain
// Holds result lists in a short queue and delivers their entries one per
// cycle in order while pop_i is asserted.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_i,
  input  wire snfcs_pkg::res_list_t list_i,
  output logic                      full_o,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output snfcs_pkg::out_item_t      res_o
);
  import snfcs_pkg::*;

  res_list_t   mem_q [2];
  logic [1:0]  cnt_q;
  logic        wp_q, rp_q;
  logic [2:0]  sub_q;
  logic        adv;
  logic        wr_en;

  assign wr_en = wr_i && list_i.n != '0;
  assign empty_o = cnt_q == '0;
  assign full_o = cnt_q == 2'd2;
  assign res_o = mem_q[rp_q].res[sub_q];
  assign adv = pop_i && !empty_o && (sub_q == mem_q[rp_q].n - 3'd1);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= list_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0; sub_q <= '0;
    end else begin
      if (wr_en) wp_q <= ~wp_q;
      if (pop_i && !empty_o) begin
        if (adv) begin
          sub_q <= '0; rp_q <= ~rp_q;
        end else begin
          sub_q <= sub_q + 3'd1;
        end
      end
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, adv};
    end
  end

endmodule
`default_nettype wire

FILE: design/spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer: serial NOR flash master sequencer
// Turns command, payload, received-byte and tick transactions into SPI byte
// transactions with frame-end marks, read data and completion results.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake        | Payload
//  ---------+-----------+------------------+-------------------------------
//  input    | in        | push_i / full_o  | in_item_t (func .. value)
//  result   | out       | empty_o / pop_i  | out_item_t (spi_byte .. last)
//  config   | in        | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// The front part takes one input transaction per cycle unless the queue is
// full, and computes all of its results in that cycle, zero to six of them.
// Results drain from a two-entry list queue at one per cycle while pop_i is
// asserted, each list holding its entry until its last result is popped;
// input stalls only when both entries are occupied.
// Reset clears the operation state, the queue and sets default timeouts.
// ----------------------------------------------------------------------------
`default_nettype none
module spi_nor_flash_command_sequencer #(
  parameter int unsigned SectorBytes = 4096,
  parameter int unsigned PageBytes   = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  output logic                      full_o,
  input  wire snfcs_pkg::in_item_t  in_i,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output snfcs_pkg::out_item_t      out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i
);
  import snfcs_pkg::*;

  res_list_t list;
  logic      take;

  // An input transaction is taken whenever one is pushed and the queue has room.
  assign take = push_i && !full_o;

  snfcs_front #(.SectorBytes(SectorBytes), .PageBytes(PageBytes)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .take_i(take), .item_i(in_i), .list_o(list)
  );

  snfcs_back u_back (
    .clk_i, .rst_ni, .wr_i(take), .list_i(list),
    .full_o, .empty_o, .pop_i, .res_o(out_o)
  );

  // A delivered result never carries both an SPI byte and read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> !(out_o.spi_valid && out_o.read_valid))
    else $error("result carries both spi byte and read data");

  // A taken transaction with at least one result leaves the queue non-empty afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && list.n != '0) |=> !empty_o)
    else $error("queued results lost");

endmodule
`default_nettype wire
